>>> hw/rtl/assert_macros.svh
// Assertion helpers for the property checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk_i, muted while rst_ni is low.
`define MVT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A signal must hold its value into the cycle after cond.
`define MVT_ASSERT_HOLD(name, cond, sig, msg) \
  `MVT_ASSERT(name, (cond) |=> $stable(sig), msg)

`endif

>>> hw/rtl/mvt_pkg.sv
`default_nettype none

package mvt_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned VEC_N     = 4;
  localparam int unsigned MAT_N     = VEC_N * VEC_N;
  localparam int unsigned IDX_W     = 2;
  localparam int unsigned PROD_W    = 2 * DATA_W - FRAC_BITS;
  localparam int unsigned SUM_W     = PROD_W + 2;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_POINT = 2'd1,
    ACT_DIR   = 2'd2,
    ACT_VEC4  = 2'd3
  } action_e;

  typedef logic signed [DATA_W-1:0] fix_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // Handshake and side info passed between pipeline stages
  typedef struct packed {
    logic valid;
    logic vec4;
  } stage_ctl_t;

  localparam fix_t FIX_ONE = fix_t'(1) << FRAC_BITS;

  function automatic fix_t identity_entry(logic [2*IDX_W-1:0] idx);
    return (idx[IDX_W-1:0] == idx[2*IDX_W-1:IDX_W]) ? FIX_ONE : '0;
  endfunction

  function automatic fix_t saturate(sum_t s);
    fix_t r;
    if (s[SUM_W-1:DATA_W-1] == {(SUM_W-DATA_W+1){s[SUM_W-1]}}) begin
      r = s[DATA_W-1:0];
    end else if (s[SUM_W-1]) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mvt_in_if.sv
`default_nettype none

interface mvt_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          action;
  logic [mvt_pkg::IDX_W-1:0]           row;
  logic [mvt_pkg::IDX_W-1:0]           col;
  logic signed [mvt_pkg::DATA_W-1:0]   entry_value;
  logic signed [mvt_pkg::DATA_W-1:0]   in_x;
  logic signed [mvt_pkg::DATA_W-1:0]   in_y;
  logic signed [mvt_pkg::DATA_W-1:0]   in_z;
  logic signed [mvt_pkg::DATA_W-1:0]   in_w;

  modport source (
    output valid, action, row, col, entry_value, in_x, in_y, in_z, in_w,
    input  ready
  );

  modport sink (
    input  valid, action, row, col, entry_value, in_x, in_y, in_z, in_w,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/mvt_out_if.sv
`default_nettype none

interface mvt_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mvt_pkg::DATA_W-1:0]   out_x;
  logic signed [mvt_pkg::DATA_W-1:0]   out_y;
  logic signed [mvt_pkg::DATA_W-1:0]   out_z;
  logic signed [mvt_pkg::DATA_W-1:0]   out_w;

  modport source (
    output valid, out_x, out_y, out_z, out_w,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_z, out_w,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/matrix_vector_transform.sv
// 4x4 matrix-vector transform, Q16.16 fixed point.
// vin_i (valid/ready): one transaction either writes one matrix entry
// (action 0, row, col, entry_value) or transforms a vector: action 1 point
// (w = 1.0), action 2 direction (w = 0), action 3 full 4-vector (in_w).
// vout_o (valid/ready): one transaction per transform, with the saturated
// dot products of rows 0..2 and, for action 3 only, row 3 (else zero).
// Entry writes produce no output transaction.
// A transform passes three register stages in order before vout_o: the
// input register, the multiplier register and the result register.
// Throughput: one transaction per clock while vout_o is ready; the sixteen
// entry products are computed in parallel in one stage.
// A write followed directly by a transform is applied before it.
// Reset: all stages empty, the matrix is loaded with identity at once.
// Stall: each stage only holds while full and blocked, so bubbles are
// squeezed out and vin_i keeps accepting until all three stages are full.
`default_nettype none

module matrix_vector_transform (
  input  logic       clk_i,
  input  logic       rst_ni,
  mvt_in_if.sink     vin_i,
  mvt_out_if.source  vout_o
);

  mvt_pkg::stage_ctl_t req;
  mvt_pkg::stage_ctl_t ctl;
  mvt_pkg::fix_t       vec [mvt_pkg::VEC_N];
  mvt_pkg::fix_t       mat [mvt_pkg::MAT_N];
  mvt_pkg::prod_t      prod [mvt_pkg::MAT_N];
  logic                req_ready;
  logic                ctl_ready;

  mvt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vin_i       (vin_i),
    .req_o       (req),
    .vec_o       (vec),
    .mat_o       (mat),
    .req_ready_i (req_ready)
  );

  mvt_mul u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .vec_i       (vec),
    .mat_i       (mat),
    .req_ready_o (req_ready),
    .ctl_o       (ctl),
    .prod_o      (prod),
    .ctl_ready_i (ctl_ready)
  );

  mvt_sum u_sum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .prod_i      (prod),
    .ctl_ready_o (ctl_ready),
    .vout_o      (vout_o)
  );

endmodule

`default_nettype wire

>>> hw/rtl/mvt_front.sv
`default_nettype none

// Input register and matrix store. Entry writes commit here, in order,
// so a transform that follows a write always sees the new entry.
module mvt_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mvt_in_if.sink               vin_i,
  output mvt_pkg::stage_ctl_t  req_o,
  output mvt_pkg::fix_t        vec_o [mvt_pkg::VEC_N],
  output mvt_pkg::fix_t        mat_o [mvt_pkg::MAT_N],
  input  logic                 req_ready_i
);

  logic                         s1_valid_q;
  mvt_pkg::action_e             s1_action_q;
  logic [mvt_pkg::IDX_W-1:0]    s1_row_q;
  logic [mvt_pkg::IDX_W-1:0]    s1_col_q;
  mvt_pkg::fix_t                s1_entry_q;
  mvt_pkg::fix_t                s1_vec_q [mvt_pkg::VEC_N];
  mvt_pkg::fix_t                mat_q [mvt_pkg::MAT_N];

  logic s1_write;
  logic s1_en;

  assign s1_write = (s1_action_q == mvt_pkg::ACT_WRITE);
  // a write leaves the stage on its own, it sends nothing downstream
  assign s1_en    = !s1_valid_q || s1_write || req_ready_i;
  assign vin_i.ready = s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_en) begin
      s1_valid_q <= vin_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && vin_i.valid) begin
      s1_action_q <= mvt_pkg::action_e'(vin_i.action);
      s1_row_q    <= vin_i.row;
      s1_col_q    <= vin_i.col;
      s1_entry_q  <= vin_i.entry_value;
      s1_vec_q[0] <= vin_i.in_x;
      s1_vec_q[1] <= vin_i.in_y;
      s1_vec_q[2] <= vin_i.in_z;
      s1_vec_q[3] <= vin_i.in_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mvt_pkg::MAT_N; i++) begin
        mat_q[i] <= mvt_pkg::identity_entry((2*mvt_pkg::IDX_W)'(i));
      end
    end else if (s1_valid_q && s1_write) begin
      mat_q[{s1_row_q, s1_col_q}] <= s1_entry_q;
    end
  end

  always_comb begin
    vec_o[0] = s1_vec_q[0];
    vec_o[1] = s1_vec_q[1];
    vec_o[2] = s1_vec_q[2];
    unique case (s1_action_q)
      mvt_pkg::ACT_POINT: vec_o[3] = mvt_pkg::FIX_ONE;
      mvt_pkg::ACT_DIR:   vec_o[3] = '0;
      mvt_pkg::ACT_VEC4:  vec_o[3] = s1_vec_q[3];
      default:            vec_o[3] = '0;
    endcase
  end

  assign mat_o      = mat_q;
  assign req_o.valid = s1_valid_q && !s1_write;
  assign req_o.vec4  = (s1_action_q == mvt_pkg::ACT_VEC4);

endmodule

`default_nettype wire

>>> hw/rtl/mvt_mul.sv
`default_nettype none

// Sixteen parallel multipliers, one per matrix entry, floor-shifted products
// registered.
module mvt_mul (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mvt_pkg::stage_ctl_t  req_i,
  input  mvt_pkg::fix_t        vec_i [mvt_pkg::VEC_N],
  input  mvt_pkg::fix_t        mat_i [mvt_pkg::MAT_N],
  output logic                 req_ready_o,
  output mvt_pkg::stage_ctl_t  ctl_o,
  output mvt_pkg::prod_t       prod_o [mvt_pkg::MAT_N],
  input  logic                 ctl_ready_i
);

  logic                               s2_valid_q;
  logic                               s2_vec4_q;
  mvt_pkg::prod_t                     prod_q [mvt_pkg::MAT_N];
  logic signed [2*mvt_pkg::DATA_W-1:0] full_p [mvt_pkg::MAT_N];
  logic                               s2_en;

  for (genvar i = 0; i < mvt_pkg::MAT_N; i++) begin : g_mul
    assign full_p[i] = mat_i[i] * vec_i[i % mvt_pkg::VEC_N];
  end

  assign s2_en       = !s2_valid_q || ctl_ready_i;
  assign req_ready_o = s2_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_en) begin
      s2_valid_q <= req_i.valid;
    end
  end

  // dropping the low bits of the exact product is floor division
  always_ff @(posedge clk_i) begin
    if (s2_en && req_i.valid) begin
      s2_vec4_q <= req_i.vec4;
      for (int i = 0; i < mvt_pkg::MAT_N; i++) begin
        prod_q[i] <= full_p[i][2*mvt_pkg::DATA_W-1:mvt_pkg::FRAC_BITS];
      end
    end
  end

  assign ctl_o.valid = s2_valid_q;
  assign ctl_o.vec4  = s2_vec4_q;
  assign prod_o      = prod_q;

endmodule

`default_nettype wire

>>> hw/rtl/mvt_sum.sv
`default_nettype none

// Row sums, saturation and the result register.
module mvt_sum (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mvt_pkg::stage_ctl_t  ctl_i,
  input  mvt_pkg::prod_t       prod_i [mvt_pkg::MAT_N],
  output logic                 ctl_ready_o,
  mvt_out_if.source            vout_o
);

  logic              out_valid_q;
  mvt_pkg::fix_t     res_q [mvt_pkg::VEC_N];
  mvt_pkg::fix_t     res_d [mvt_pkg::VEC_N];
  mvt_pkg::sum_t     row_sum [mvt_pkg::VEC_N];
  logic              out_en;

  always_comb begin
    for (int r = 0; r < mvt_pkg::VEC_N; r++) begin
      row_sum[r] = mvt_pkg::sum_t'(prod_i[r*mvt_pkg::VEC_N])
                 + mvt_pkg::sum_t'(prod_i[r*mvt_pkg::VEC_N + 1])
                 + mvt_pkg::sum_t'(prod_i[r*mvt_pkg::VEC_N + 2])
                 + mvt_pkg::sum_t'(prod_i[r*mvt_pkg::VEC_N + 3]);
      res_d[r] = mvt_pkg::saturate(row_sum[r]);
    end
    // w row only reported for full 4-vectors
    if (!ctl_i.vec4) begin
      res_d[mvt_pkg::VEC_N-1] = '0;
    end
  end

  assign out_en      = !out_valid_q || vout_o.ready;
  assign ctl_ready_o = out_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && ctl_i.valid) begin
      res_q <= res_d;
    end
  end

  assign vout_o.valid = out_valid_q;
  assign vout_o.out_x = res_q[0];
  assign vout_o.out_y = res_q[1];
  assign vout_o.out_z = res_q[2];
  assign vout_o.out_w = res_q[3];

endmodule

`default_nettype wire

>>> hw/rtl/mvt_checker.sv
`default_nettype none

`include "assert_macros.svh"

module mvt_prop_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic [1:0]                   in_action_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [mvt_pkg::DATA_W-1:0]   out_x_i,
  input logic [mvt_pkg::DATA_W-1:0]   out_y_i,
  input logic [mvt_pkg::DATA_W-1:0]   out_z_i,
  input logic [mvt_pkg::DATA_W-1:0]   out_w_i
);

  logic                           out_stall;
  logic                           in_xform;
  logic [4*mvt_pkg::DATA_W-1:0]   out_payload;

  assign out_stall   = out_valid_i && !out_ready_i;
  assign in_xform    = in_valid_i && in_ready_i && (in_action_i != mvt_pkg::ACT_WRITE);
  assign out_payload = {out_x_i, out_y_i, out_z_i, out_w_i};

  `MVT_ASSERT(a_out_valid_hold, out_stall |=> out_valid_i, "output valid dropped while stalled")
  `MVT_ASSERT_HOLD(a_out_data_hold, out_stall, out_payload, "output payload changed in stall")
  `MVT_ASSERT(a_in_ready_when_empty, !out_valid_i |-> in_ready_i, "input blocked, output empty")
  `MVT_ASSERT(a_xform_latency, in_xform ##1 out_ready_i [*2] |=> out_valid_i, "result late")

endmodule

bind matrix_vector_transform mvt_prop_checker u_mvt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (vin_i.valid),
  .in_ready_i  (vin_i.ready),
  .in_action_i (vin_i.action),
  .out_valid_i (vout_o.valid),
  .out_ready_i (vout_o.ready),
  .out_x_i     (vout_o.out_x),
  .out_y_i     (vout_o.out_y),
  .out_z_i     (vout_o.out_z),
  .out_w_i     (vout_o.out_w)
);

`default_nettype wire

>>> test/mvt_checker.sv
`timescale 1ns / 1ps

module mvt_checker (
  input  logic clk_i,
  input  logic rst_ni,
  mvt_in_if    vin_mon,
  mvt_out_if   vout_mon,
  output int   fail_count_o,
  output int   pending_o
);
  import mvt_pkg::*;

  typedef struct packed {
    fix_t x;
    fix_t y;
    fix_t z;
    fix_t w;
  } vertex_t;

  fix_t    matrix_q [4][4];
  vertex_t vertex_q [$];
  int      fail_count = 0;

  assign fail_count_o = fail_count;

  // Products floor toward minus infinity; row sum clamps to 32 bits.
  function automatic fix_t dot_row(int unsigned r, longint vx, longint vy, longint vz,
                                   longint vw);
    longint acc;
    longint vec [4];
    vec = '{vx, vy, vz, vw};
    acc = 0;
    for (int c = 0; c < 4; c++) begin
      acc += (longint'(matrix_q[r][c]) * vec[c]) >>> FRAC_BITS;
    end
    if (acc > longint'(32'sh7fff_ffff)) return 32'sh7fff_ffff;
    if (acc < -longint'(64'sd2147483648)) return 32'sh8000_0000;
    return fix_t'(acc);
  endfunction

  function automatic vertex_t transform_vertex(action_e act, fix_t x, fix_t y, fix_t z,
                                               fix_t w);
    vertex_t res;
    longint  vw;
    case (act)
      ACT_POINT: vw = longint'(FIX_ONE);
      ACT_DIR:   vw = 0;
      default:   vw = longint'(w);
    endcase
    res.x = dot_row(0, x, y, z, vw);
    res.y = dot_row(1, x, y, z, vw);
    res.z = dot_row(2, x, y, z, vw);
    res.w = (act == ACT_VEC4) ? dot_row(3, x, y, z, vw) : '0;
    return res;
  endfunction

  task automatic check_field(string name, fix_t exp_val, fix_t got_val);
    if (got_val !== exp_val) begin
      $error("%s expected %0d got %0d", name, exp_val, got_val);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    vertex_t exp_v;
    if (!rst_ni) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 4; c++) begin
          matrix_q[r][c] = (r == c) ? FIX_ONE : '0;
        end
      end
      vertex_q.delete();
      pending_o <= 0;
    end else begin
      if (vout_mon.valid && vout_mon.ready) begin
        if (vertex_q.size() == 0) begin
          $error("result transaction with no transform pending");
          fail_count++;
        end else begin
          exp_v = vertex_q.pop_front();
          check_field("out_x", exp_v.x, vout_mon.out_x);
          check_field("out_y", exp_v.y, vout_mon.out_y);
          check_field("out_z", exp_v.z, vout_mon.out_z);
          check_field("out_w", exp_v.w, vout_mon.out_w);
        end
      end
      if (vin_mon.valid && vin_mon.ready) begin
        if (action_e'(vin_mon.action) == ACT_WRITE) begin
          matrix_q[vin_mon.row][vin_mon.col] = vin_mon.entry_value;
        end else begin
          vertex_q.push_back(transform_vertex(action_e'(vin_mon.action), vin_mon.in_x,
                                              vin_mon.in_y, vin_mon.in_z, vin_mon.in_w));
        end
      end
      pending_o <= vertex_q.size();
    end
  end

endmodule

>>> test/tb_matrix_vector_transform.sv
`timescale 1ns / 1ps

module tb_matrix_vector_transform;
  import mvt_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1850;
  localparam fix_t MAX_FIX = 32'sh7fff_ffff;
  localparam fix_t MIN_FIX = 32'sh8000_0000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit   steady = 1'b0;
  int   items_sent = 0;
  int   fail_count;
  int   pending;

  mvt_in_if  vin ();
  mvt_out_if vout ();

  matrix_vector_transform DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vin_i  (vin),
    .vout_o (vout)
  );

  mvt_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .vin_mon      (vin),
    .vout_mon     (vout),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #3ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic fix_t rand_fix();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return fix_t'($urandom_range(0, 32'h0008_0000)) - fix_t'(32'h0004_0000);
    if (sel < 8) return fix_t'($urandom);
    if (sel == 9) return fix_t'($urandom_range(0, 32'h0800_0000)) - fix_t'(32'h0400_0000);
    case ($urandom_range(0, 6))
      0:       return MAX_FIX;
      1:       return MIN_FIX;
      2:       return '0;
      3:       return fix_t'(1);
      4:       return '1;
      5:       return FIX_ONE;
      default: return -FIX_ONE;
    endcase
  endfunction

  task automatic send(action_e act, logic [1:0] r, logic [1:0] c, fix_t ev, fix_t x,
                      fix_t y, fix_t z, fix_t w);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      vin.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    vin.valid       <= 1'b1;
    vin.action      <= act;
    vin.row         <= r;
    vin.col         <= c;
    vin.entry_value <= ev;
    vin.in_x        <= x;
    vin.in_y        <= y;
    vin.in_z        <= z;
    vin.in_w        <= w;
    do @(posedge clk_i); while (!vin.ready);
    items_sent++;
  endtask

  // vector fields are don't-care on a write
  task automatic write_entry(logic [1:0] r, logic [1:0] c, fix_t v);
    send(ACT_WRITE, r, c, v, rand_fix(), rand_fix(), rand_fix(), rand_fix());
  endtask

  task automatic transform(action_e act, fix_t x, fix_t y, fix_t z, fix_t w);
    send(act, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), rand_fix(), x, y, z, w);
  endtask

  task automatic drain();
    vin.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // result side back-pressure
  initial begin : result_sink
    int stall;
    int burst;
    vout.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = steady ? 0 : idle_len();
      if (stall > 0) begin
        vout.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      vout.ready <= 1'b1;
      burst = $urandom_range(1, 8);
      repeat (burst) @(posedge clk_i);
    end
  end

  initial begin : stimulus
    int          perm [16];
    int          tmp;
    int          j;
    int          n;
    int unsigned mode;
    bit          mid_drained;
    mid_drained     = 1'b0;
    vin.valid       <= 1'b0;
    vin.action      <= ACT_WRITE;
    vin.row         <= '0;
    vin.col         <= '0;
    vin.entry_value <= '0;
    vin.in_x        <= '0;
    vin.in_y        <= '0;
    vin.in_z        <= '0;
    vin.in_w        <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity matrix, all transform kinds, field extremes
    transform(ACT_POINT, 32'sh0001_8000, 32'shfffe_0000, '0, 32'sh1234_5678);
    transform(ACT_DIR, MAX_FIX, MIN_FIX, fix_t'(1), MAX_FIX);
    transform(ACT_VEC4, MIN_FIX, MAX_FIX, '1, MIN_FIX);
    transform(ACT_VEC4, '0, '0, '0, '0);
    // translation on x: point adds it, direction does not
    write_entry(2'd0, 2'd3, 32'sh000a_0000);
    transform(ACT_POINT, FIX_ONE, FIX_ONE, FIX_ONE, '0);
    transform(ACT_DIR, FIX_ONE, FIX_ONE, FIX_ONE, '0);
    transform(ACT_POINT, MAX_FIX, '0, '0, '0);
    // negative clamp on y
    write_entry(2'd1, 2'd3, MIN_FIX);
    transform(ACT_POINT, '0, MIN_FIX, '0, '0);
    // one-lsb negative product floors to -1
    write_entry(2'd2, 2'd1, '1);
    transform(ACT_VEC4, '0, fix_t'(1), '0, '0);
    // min * min drives row 0 past the 32-bit range, so it saturates
    write_entry(2'd0, 2'd0, MIN_FIX);
    transform(ACT_VEC4, MIN_FIX, '0, '0, '0);
    write_entry(2'd3, 2'd3, MAX_FIX);
    write_entry(2'd3, 2'd0, MIN_FIX);
    transform(ACT_VEC4, MAX_FIX, fix_t'(5), fix_t'(7), MAX_FIX);
    write_entry(2'd3, 2'd2, 32'sh0000_8000);
    // row 3 nonzero, but out_w must stay zero here
    transform(ACT_POINT, rand_fix(), rand_fix(), rand_fix(), rand_fix());
    transform(ACT_DIR, MIN_FIX, MIN_FIX, MIN_FIX, MIN_FIX);

    while (items_sent < RANDOM_ITEMS + 20) begin
      steady = ($urandom_range(0, 5) == 0);
      mode = $urandom_range(0, 9);
      if (mode < 4) begin
        // full matrix load in shuffled order, then a vertex burst
        for (int i = 0; i < 16; i++) perm[i] = i;
        for (int i = 15; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        for (int i = 0; i < 16; i++) begin
          write_entry(2'(perm[i] >> 2), 2'(perm[i] & 3), rand_fix());
        end
        n = $urandom_range(8, 30);
        repeat (n) begin
          transform(action_e'($urandom_range(1, 3)), rand_fix(), rand_fix(), rand_fix(),
                    rand_fix());
        end
      end else if (mode < 9) begin
        n = $urandom_range(10, 30);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) begin
            write_entry(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), rand_fix());
          end else begin
            transform(action_e'($urandom_range(1, 3)), rand_fix(), rand_fix(), rand_fix(),
                      rand_fix());
          end
        end
      end else begin
        // back to identity so results stay in range for a while
        for (int i = 0; i < 16; i++) begin
          write_entry(2'(i >> 2), 2'(i & 3), ((i >> 2) == (i & 3)) ? FIX_ONE : '0);
        end
        n = $urandom_range(5, 20);
        repeat (n) begin
          transform(action_e'($urandom_range(1, 3)), rand_fix(), rand_fix(), rand_fix(),
                    rand_fix());
        end
      end
      if ((!mid_drained && items_sent > RANDOM_ITEMS / 2) || $urandom_range(0, 9) == 0) begin
        mid_drained = 1'b1;
        drain();
      end
    end

    steady = 1'b0;
    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
